// ----- rtl/tae_pkg.sv -----
`default_nettype none
package tae_pkg;

  localparam int LAG_W = 11;
  localparam int OUT_W = 40;
  localparam int SUM_W = 64;
  localparam int FRAC_BITS = 16;

  typedef struct packed {
    logic accept;
    logic rd_n;
    logic rd_2n;
    logic diff;
    logic sq;
    logic acc;
    logic den1;
    logic den2;
    logic unit_start;
    logic unit_sel;
    logic take_t;
    logic take_a;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic unit_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/tae_ctrl.sv -----
`default_nettype none
module tae_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tae_pkg::sts_t sts,
  output tae_pkg::cmd_t      cmd
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RDN   = 4'd1;
  localparam logic [3:0] ST_RD2N  = 4'd2;
  localparam logic [3:0] ST_DIFF  = 4'd3;
  localparam logic [3:0] ST_SQ    = 4'd4;
  localparam logic [3:0] ST_ACC   = 4'd5;
  localparam logic [3:0] ST_DEN1  = 4'd6;
  localparam logic [3:0] ST_DEN2  = 4'd7;
  localparam logic [3:0] ST_TST   = 4'd8;
  localparam logic [3:0] ST_TWAIT = 4'd9;
  localparam logic [3:0] ST_AST   = 4'd10;
  localparam logic [3:0] ST_AWAIT = 4'd11;
  localparam logic [3:0] ST_LOAD  = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_RDN;
        end
      end
      ST_RDN: begin
        cmd.rd_n = 1'b1;
        state_next = ST_RD2N;
      end
      ST_RD2N: begin
        cmd.rd_2n = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq = 1'b1;
        state_next = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc = 1'b1;
        state_next = sts.last ? ST_DEN1 : ST_IDLE;
      end
      ST_DEN1: begin
        cmd.den1 = 1'b1;
        state_next = ST_DEN2;
      end
      ST_DEN2: begin
        cmd.den2 = 1'b1;
        state_next = ST_TST;
      end
      ST_TST: begin
        cmd.unit_start = 1'b1;
        state_next = ST_TWAIT;
      end
      ST_TWAIT: begin
        cmd.take_t = 1'b1;
        if (sts.unit_done) state_next = ST_AST;
      end
      ST_AST: begin
        cmd.unit_start = 1'b1;
        cmd.unit_sel = 1'b1;
        state_next = ST_AWAIT;
      end
      ST_AWAIT: begin
        cmd.take_a = 1'b1;
        if (sts.unit_done) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tae_divsqrt.sv -----
`default_nettype none
// Computes floor(sqrt((num << 16) / den)): a restoring divider, one quotient
// bit a cycle, followed by a digit-by-digit square root, one root bit a cycle.
module tae_divsqrt (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [tae_pkg::SUM_W-1:0]   num,
  input  wire logic [tae_pkg::SUM_W-1:0]   den,
  output logic                             done,
  output logic [tae_pkg::OUT_W-1:0]        root
);

  localparam int NUM_W = tae_pkg::SUM_W + tae_pkg::FRAC_BITS;
  localparam int RT_W  = tae_pkg::OUT_W;
  localparam int SR_W  = RT_W + 4;
  localparam int CNT_W = $clog2(NUM_W + 1);

  logic                     div_busy;
  logic                     sqrt_busy;
  logic [CNT_W-1:0]         steps;
  logic [NUM_W-1:0]         numer;
  logic [NUM_W-1:0]         quot;
  logic [tae_pkg::SUM_W-1:0] divisor;
  logic [tae_pkg::SUM_W-1:0] rem;
  logic [tae_pkg::SUM_W:0]   rem_sh;
  logic [SR_W-1:0]          srem;
  logic [SR_W-1:0]          srem_sh;
  logic [SR_W-1:0]          trial;

  assign rem_sh  = {rem, numer[NUM_W-1]};
  assign srem_sh = {srem[SR_W-3:0], quot[NUM_W-1:NUM_W-2]};
  assign trial   = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy  <= 1'b0;
      sqrt_busy <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        div_busy <= 1'b1;
      end else if (div_busy && steps == CNT_W'(NUM_W - 1)) begin
        div_busy  <= 1'b0;
        sqrt_busy <= 1'b1;
      end else if (sqrt_busy && steps == CNT_W'(RT_W - 1)) begin
        sqrt_busy <= 1'b0;
        done      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      numer   <= {num, tae_pkg::FRAC_BITS'(0)};
      divisor <= den;
      rem     <= '0;
      quot    <= '0;
      steps   <= '0;
      srem    <= '0;
      root    <= '0;
    end else if (div_busy) begin
      numer <= {numer[NUM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, divisor}) begin
        rem  <= tae_pkg::SUM_W'(rem_sh - {1'b0, divisor});
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[tae_pkg::SUM_W-1:0];
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
      steps <= (steps == CNT_W'(NUM_W - 1)) ? '0 : steps + 1'b1;
    end else if (sqrt_busy) begin
      quot <= {quot[NUM_W-3:0], 2'b00};
      if (srem_sh >= trial) begin
        srem <= srem_sh - trial;
        root <= {root[RT_W-2:0], 1'b1};
      end else begin
        srem <= srem_sh;
        root <= {root[RT_W-2:0], 1'b0};
      end
      steps <= steps + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tae_datapath.sv -----
`default_nettype none
module tae_datapath #(
  parameter int MAX_LAG     = 1024,
  parameter int MAX_SAMPLES = 1048576,
  parameter int SAMPLE_BITS = 20
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tae_pkg::cmd_t               cmd,
  output tae_pkg::sts_t                    sts,
  input  wire logic [SAMPLE_BITS-1:0]      in_sample,
  input  wire logic                        in_last,
  input  wire logic                        cfg_wr_en,
  input  wire logic [tae_pkg::LAG_W-1:0]   cfg_wr_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [tae_pkg::OUT_W-1:0]        tdev_value,
  output logic [tae_pkg::OUT_W-1:0]        adev_value,
  output logic                             tdev_valid,
  output logic                             adev_valid,
  output logic                             sum_saturated
);

  localparam int DEPTH = 2 * MAX_LAG;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int DW    = SAMPLE_BITS + 2;
  localparam int SQ_W  = 2 * DW;
  localparam int LW    = tae_pkg::LAG_W;
  localparam int SW    = tae_pkg::SUM_W;
  localparam int PROD_W = 2 * LW + CNT_W;

  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rdata;
  logic [PTR_W-1:0]       raddr;
  logic [31:0]            back_raw;
  logic [31:0]            back_mod;

  logic [LW-1:0]          lag;
  logic [LW-1:0]          n;
  logic [LW-1:0]          n_eff;
  logic signed [SAMPLE_BITS-1:0] x;
  logic signed [SAMPLE_BITS-1:0] xn;
  logic                   last;
  logic [PTR_W-1:0]       wp;
  logic [CNT_W-1:0]       cnt;
  logic signed [DW-1:0]   d1;
  logic signed [DW-1:0]   d2;
  logic [SQ_W-1:0]        sq1;
  logic [SQ_W-1:0]        sq2;
  logic [SW-1:0]          sum1;
  logic [SW-1:0]          sum2;
  logic [SW:0]            add1;
  logic [SW:0]            add2;
  logic                   sat;
  logic                   have_n;
  logic                   have_2n;
  logic [CNT_W-1:0]       c1;
  logic [CNT_W-1:0]       c2;
  logic [2*LW-1:0]        nn;
  logic [SW-1:0]          den_t;
  logic [SW-1:0]          den_a;
  logic                   tv;
  logic                   av;
  logic [tae_pkg::OUT_W-1:0] tdev_r;
  logic [tae_pkg::OUT_W-1:0] adev_r;
  logic                   unit_done;
  logic [tae_pkg::OUT_W-1:0] unit_root;

  always_comb begin
    if (lag == '0) begin
      n_eff = LW'(1);
    end else if (32'(lag) > 32'(MAX_LAG)) begin
      n_eff = LW'(MAX_LAG);
    end else begin
      n_eff = lag;
    end
  end

  // Ring position a lag or twice a lag behind the write pointer.
  always_comb begin
    back_raw = 32'(wp) + 32'(DEPTH) - (cmd.rd_2n ? (32'(n) << 1) : 32'(n));
    back_mod = (back_raw >= 32'(DEPTH)) ? back_raw - 32'(DEPTH) : back_raw;
    raddr    = back_mod[PTR_W-1:0];
  end

  assign have_n  = 32'(cnt) >= 32'(n);
  assign have_2n = 32'(cnt) >= (32'(n) << 1);
  assign add1 = {1'b0, sum1} + {1'b0, SW'(sq1)};
  assign add2 = {1'b0, sum2} + {1'b0, SW'(sq2)};

  always_ff @(posedge clk) begin
    if (cmd.rd_n || cmd.rd_2n) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      mem[wp] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lag <= LW'(1);
    end else if (cfg_wr_en) begin
      lag <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      x    <= in_sample;
      last <= in_last;
      n    <= n_eff;
    end
    if (cmd.rd_2n) begin
      xn <= rdata;
    end
    // The read data here is the sample two lags back.
    if (cmd.diff) begin
      d1 <= have_n ? DW'(x) - DW'(xn) : '0;
      d2 <= have_2n ? DW'(x) - (DW'(xn) <<< 1) + DW'($signed(rdata)) : '0;
    end
    if (cmd.sq) begin
      sq1 <= SQ_W'(d1 * d1);
      sq2 <= SQ_W'(d2 * d2);
    end
    if (cmd.den1) begin
      c1 <= CNT_W'(32'(cnt) - 32'(n));
      c2 <= CNT_W'(32'(cnt) - (32'(n) << 1));
      nn <= n * n;
      tv <= 32'(cnt) > (32'(n) << 1);
      av <= 32'(cnt) > 32'(n);
    end
    if (cmd.den2) begin
      den_t <= SW'(c2) * SW'(6);
      den_a <= SW'({PROD_W'(nn) * PROD_W'(c1), 1'b0});
    end
    if (cmd.take_t && unit_done) begin
      tdev_r <= unit_root;
    end
    if (cmd.take_a && unit_done) begin
      adev_r <= unit_root;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.load_out) begin
      wp   <= '0;
      cnt  <= '0;
      sum1 <= '0;
      sum2 <= '0;
      sat  <= 1'b0;
    end else if (cmd.acc) begin
      wp   <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
      sum1 <= add1[SW] ? '1 : add1[SW-1:0];
      sum2 <= add2[SW] ? '1 : add2[SW-1:0];
      if (32'(cnt) < 32'(MAX_SAMPLES)) begin
        cnt <= cnt + 1'b1;
        if (add1[SW] || add2[SW]) sat <= 1'b1;
      end else begin
        sat <= 1'b1;
      end
    end
  end

  tae_divsqrt u_divsqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.unit_start),
    .num   (cmd.unit_sel ? sum1 : sum2),
    .den   (cmd.unit_sel ? den_a : den_t),
    .done  (unit_done),
    .root  (unit_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      tdev_value    <= tv ? tdev_r : '0;
      adev_value    <= av ? adev_r : '0;
      tdev_valid    <= tv;
      adev_valid    <= av;
      sum_saturated <= sat;
    end
  end

  always_comb begin
    sts.last      = last;
    sts.unit_done = unit_done;
    sts.out_free  = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

// ----- rtl/tdev_adev_estimator_unit.sv -----
`default_nettype none
// Overlapping TDEV/ADEV estimator. Each input beat carries one signed phase
// sample and is worked in steps: the beat is taken, two reads of the single-port
// delay line (one lag and two lags back), the difference, the squares and the
// saturating accumulate with the write of the new sample. The beat marked
// tlast then adds two denominator steps, after which one shared divide-and-root
// unit runs twice (TDEV then ADEV), each run a divide and then a root, plus start
// and hand-over. The result beat sits in an output register; the next run may
// begin while it waits to be taken, and only a second result waits for the
// first to leave.
module tdev_adev_estimator_unit #(
  parameter int MAX_LAG     = 1024,
  parameter int MAX_SAMPLES = 1048576,
  parameter int SAMPLE_BITS = 20
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   s_axis_tvalid,
  output logic                                        s_axis_tready,
  // phase sample [SAMPLE_BITS-1:0]
  input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  input  wire logic                                   s_axis_tlast,
  output logic                                        m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // tdev_value [39:0], adev_value [79:40]
  output logic [2*tae_pkg::OUT_W-1:0]                 m_axis_tdata,
  // tdev_valid [0], adev_valid [1], sum_saturated [2]
  output logic [2:0]                                  m_axis_tuser,
  input  wire logic                                   cfg_wr_en,
  input  wire logic [tae_pkg::LAG_W-1:0]              cfg_wr_data
);

  tae_pkg::cmd_t cmd;
  tae_pkg::sts_t sts;

  tae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tae_datapath #(
    .MAX_LAG     (MAX_LAG),
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_sample     (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_last       (s_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .tdev_value    (m_axis_tdata[tae_pkg::OUT_W-1:0]),
    .adev_value    (m_axis_tdata[2*tae_pkg::OUT_W-1:tae_pkg::OUT_W]),
    .tdev_valid    (m_axis_tuser[0]),
    .adev_valid    (m_axis_tuser[1]),
    .sum_saturated (m_axis_tuser[2])
  );

endmodule
`default_nettype wire

// ----- rtl/tae_checker.sv -----
`default_nettype none
module tae_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [79:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_tdev_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[39:0] == 40'd0)
    else $error("TDEV value not zero without its valid flag");

  a_adev_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[1] |-> m_axis_tdata[79:40] == 40'd0)
    else $error("ADEV value not zero without its valid flag");

  a_valid_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
    else $error("TDEV valid without ADEV valid");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while a sample is in work");

endmodule

bind tdev_adev_estimator_unit tae_checker u_tae_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ----- tb/testbench.sv -----
module testbench;

  localparam int OUT_W       = tae_pkg::OUT_W;
  localparam int LAG_W       = tae_pkg::LAG_W;
  localparam int HIST_DEPTH  = 2048;
  localparam int MAX_LAG     = 1024;
  localparam int MAX_SAMPLES = 1048576;
  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE      = 300;

  typedef struct {
    logic [OUT_W-1:0] tdev;
    logic [OUT_W-1:0] adev;
    logic             tdev_ok;
    logic             adev_ok;
    logic             saturated;
  } deviation_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [2*OUT_W-1:0]    m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  cfg_wr_en;
  logic [LAG_W-1:0]      cfg_wr_data;

  // Shadow copy of the estimator state.
  logic signed [19:0]    hist [HIST_DEPTH];
  int unsigned           wr_ptr;
  int unsigned           n_samples;
  logic [63:0]           sum_second;
  logic [63:0]           sum_first;
  bit                    sat_seen;
  logic [LAG_W-1:0]      lag_reg;

  deviation_t            pending_devs[$];
  int                    mismatches;
  int                    idle_cycles;
  int                    send_idle_pct;
  int                    recv_stall_pct;
  int                    hold_cycles;

  tdev_adev_estimator_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // floor(256 * sqrt(s / d)), exact.
  function automatic logic [OUT_W-1:0] q8_root(logic [63:0] s, logic [63:0] d);
    logic [127:0]     quot;
    logic [127:0]     trial;
    logic [OUT_W-1:0] root;
    quot = {48'd0, s, 16'd0} / {64'd0, d};
    root = '0;
    for (int i = OUT_W - 1; i >= 0; i--) begin
      trial = {88'd0, root | (40'd1 << i)};
      if (trial * trial <= quot) root = trial[OUT_W-1:0];
    end
    return root;
  endfunction

  function automatic void acc_square(ref logic [63:0] acc, input longint d);
    logic [64:0]   total;
    longint unsigned mag;
    mag   = d < 0 ? -d : d;
    total = {1'b0, acc} + {1'b0, mag * mag};
    if (total[64]) begin
      acc      = '1;
      sat_seen = 1'b1;
    end else begin
      acc = total[63:0];
    end
  endfunction

  function automatic void clear_run();
    wr_ptr     = 0;
    n_samples  = 0;
    sum_second = '0;
    sum_first  = '0;
    sat_seen   = 1'b0;
  endfunction

  function automatic void predict_sample(logic signed [19:0] x, bit is_last);
    int unsigned lag;
    longint      xn;
    longint      x2n;
    longint unsigned cnt;
    deviation_t  dev;
    lag = lag_reg;
    if (lag == 0) lag = 1;
    if (lag > MAX_LAG) lag = MAX_LAG;
    if (n_samples >= lag) begin
      xn = hist[(wr_ptr + HIST_DEPTH - lag) % HIST_DEPTH];
      acc_square(sum_first, longint'(x) - xn);
      if (n_samples >= 2 * lag) begin
        x2n = hist[(wr_ptr + HIST_DEPTH - 2 * lag) % HIST_DEPTH];
        acc_square(sum_second, longint'(x) - 2 * xn + x2n);
      end
    end
    hist[wr_ptr] = x;
    wr_ptr = (wr_ptr + 1) % HIST_DEPTH;
    if (n_samples < MAX_SAMPLES) n_samples++;
    else sat_seen = 1'b1;
    if (!is_last) return;
    cnt = n_samples;
    dev = '{default: '0};
    if (cnt > 2 * lag) begin
      dev.tdev    = q8_root(sum_second, 6 * (cnt - 2 * lag));
      dev.tdev_ok = 1'b1;
    end
    if (cnt > lag) begin
      dev.adev    = q8_root(sum_first, 2 * longint'(lag) * lag * (cnt - lag));
      dev.adev_ok = 1'b1;
    end
    dev.saturated = sat_seen;
    pending_devs.insert(pending_devs.size(), dev);
    clear_run();
  endfunction

  task automatic send_sample(logic signed [19:0] x, bit is_last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'd0, x};
    s_axis_tlast  <= is_last;
    do @(posedge clk); while (!s_axis_tready);
    predict_sample(x, is_last);
    @(negedge clk);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_results();
    while (pending_devs.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_lag(logic [LAG_W-1:0] value);
    wait_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    lag_reg = value;
  endtask

  function automatic logic signed [19:0] pick_sample();
    case ($urandom_range(9))
      0: return 20'sh80000;
      1: return 20'sh7FFFF;
      2, 3: return 20'($signed($urandom_range(64)) - 32);
      default: return 20'($urandom);
    endcase
  endfunction

  task automatic send_run(int len);
    for (int i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  task automatic test_directed();
    // A run of one sample is too short for either estimate.
    send_sample(20'sh7FFFF, 1'b1);
    // Two samples: ADEV only.
    send_sample(20'sh80000, 1'b0);
    send_sample(20'sh7FFFF, 1'b1);
    // Three samples at the extremes: both estimates.
    send_sample(20'sh7FFFF, 1'b0);
    send_sample(20'sh80000, 1'b0);
    send_sample(20'sh7FFFF, 1'b1);
    // Constant input gives zero deviation.
    for (int i = 0; i < 5; i++) send_sample(20'sd0, i == 4);
    send_run(8);
    stop_sending();
    // A lag of zero behaves as one.
    write_lag('0);
    send_run(3);
    send_run(6);
    stop_sending();
  endtask

  task automatic test_lags();
    int lags[4] = '{2, 3, 7, 16};
    foreach (lags[k]) begin
      write_lag(LAG_W'(lags[k]));
      for (int r = 0; r < 3; r++) send_run($urandom_range(1, 4 * lags[k] + 8));
      stop_sending();
    end
  endtask

  task automatic test_idle_phases();
    int send_pct[4] = '{0, 55, 0, 8};
    int recv_pct[4] = '{0, 0, 55, 8};
    foreach (send_pct[k]) begin
      write_lag(LAG_W'($urandom_range(1, 6)));
      send_idle_pct  = send_pct[k];
      recv_stall_pct = recv_pct[k];
      for (int r = 0; r < 4; r++) send_run($urandom_range(1, 24));
      stop_sending();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    write_lag(LAG_W'(1));
    hold_cycles = 3000;
    // Short runs pile up results while the output is held.
    for (int r = 0; r < 30; r++) send_run($urandom_range(1, 4));
    stop_sending();
    wait_results();
    send_run(12);
    stop_sending();
  endtask

  task automatic test_long_lag();
    // Lag above the maximum is clamped; the run covers ADEV at the top lag.
    write_lag('1);
    send_run(1030);
    stop_sending();
    write_lag(LAG_W'(MAX_LAG));
    send_run(40);
    stop_sending();
    write_lag(LAG_W'(1));
    recv_stall_pct = 30;
    send_idle_pct  = 30;
    for (int r = 0; r < 4; r++) send_run($urandom_range(1, 30));
    stop_sending();
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles   <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    deviation_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_devs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %h %b", m_axis_tdata,
                                       m_axis_tuser);
      end else begin
        want = pending_devs.pop_front();
        if (m_axis_tdata[OUT_W-1:0] !== want.tdev ||
            m_axis_tdata[2*OUT_W-1:OUT_W] !== want.adev ||
            m_axis_tuser[0] !== want.tdev_ok || m_axis_tuser[1] !== want.adev_ok ||
            m_axis_tuser[2] !== want.saturated) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: tdev %h/%h adev %h/%h valid %b%b/%b%b sat %b/%b",
                     m_axis_tdata[OUT_W-1:0], want.tdev, m_axis_tdata[2*OUT_W-1:OUT_W],
                     want.adev, m_axis_tuser[1], m_axis_tuser[0], want.adev_ok,
                     want.tdev_ok, m_axis_tuser[2], want.saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    mismatches     = 0;
    idle_cycles    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    lag_reg        = LAG_W'(1);
    clear_run();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_lags();
    test_idle_phases();
    test_backpressure();
    test_long_lag();
    wait_results();
    if (mismatches == 0 && pending_devs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
